// ===== hw/rtl/rebm_pkg.sv =====
// shared types and constants of the rotary encoder button menu
package rebm_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CNT_W       = 16;
    localparam int IN_W        = 8;
    localparam int OUT_W       = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_WIN  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REPRESS_GAP = 8'd3;

    localparam logic [CNT_W-1:0] DEBOUNCE_RST    = 16'd50;
    localparam logic [CNT_W-1:0] LONG_PRESS_RST  = 16'd5000;
    localparam logic [CNT_W-1:0] SECOND_WIN_RST  = 16'd6000;
    localparam logic [CNT_W-1:0] REPRESS_GAP_RST = 16'd500;

    localparam logic [2:0] KEY_IDLE     = 3'd0;
    localparam logic [2:0] KEY_DEBOUNCE = 3'd1;
    localparam logic [2:0] KEY_HELD     = 3'd2;
    localparam logic [2:0] KEY_RELEASED = 3'd3;
    localparam logic [2:0] KEY_DECIDE   = 3'd4;
    localparam logic [2:0] KEY_WAIT_UP  = 3'd5;

    localparam logic [3:0] NO_CURSOR  = 4'd10;
    localparam logic [3:0] MENU_VAR   = 4'd0;
    localparam logic [3:0] MENU_HALL  = 4'd1;
    localparam logic [3:0] MENU_MOTOR = 4'd2;
    localparam logic [3:0] MENU_D4    = 4'd3;
    localparam logic [3:0] MENU_D3    = 4'd4;
    localparam logic [3:0] MENU_D2    = 4'd5;
    localparam logic [3:0] TOP_MENU   = 4'd5;
    localparam logic [3:0] TOP_DIGIT  = 4'd9;

    localparam logic [2:0] FIELD_NONE = 3'd0;
    localparam logic [2:0] FIELD_D4   = 3'd3;
    localparam logic [2:0] FIELD_D3   = 3'd4;
    localparam logic [2:0] FIELD_D2   = 3'd5;

    localparam logic [1:0] VARIANT_LAST = 2'd2;

    typedef struct packed {
        logic short_press;
        logic long_press;
    } press_t;

endpackage

// ===== hw/rtl/rebm_button.sv =====
// button debounce and short and long press classifier; a double press gives no pulse
module rebm_button (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        btn,
    input  logic [rebm_pkg::CNT_W-1:0]  debounce_ticks,
    input  logic [rebm_pkg::CNT_W-1:0]  long_press_ticks,
    input  logic [rebm_pkg::CNT_W-1:0]  second_press_window,
    input  logic [rebm_pkg::CNT_W-1:0]  repress_gap_ticks,
    output rebm_pkg::press_t            press
);

    logic [2:0]                  mode_reg, mode_next;
    logic [rebm_pkg::CNT_W-1:0]  press_reg, press_next;
    logic [rebm_pkg::CNT_W-1:0]  release_reg, release_next;
    logic [1:0]                  click_reg, click_next;
    logic [rebm_pkg::CNT_W-1:0]  press_inc;
    logic [rebm_pkg::CNT_W-1:0]  release_inc;
    logic signed [17:0]          gap_diff;

    assign press_inc   = press_reg + 16'd1;
    assign release_inc = release_reg + 16'd1;
    assign gap_diff    = $signed({2'b00, release_inc}) - $signed({2'b00, press_reg});

    always_comb
    begin
        mode_next         = mode_reg;
        press_next        = press_reg;
        release_next      = release_reg;
        click_next        = click_reg;
        press.short_press = 1'b0;
        press.long_press  = 1'b0;
        unique case (mode_reg)
            rebm_pkg::KEY_DEBOUNCE:
            begin
                press_next = press_inc;
                if (press_inc > debounce_ticks)
                begin
                    press_next = '0;
                    if (btn)
                    begin
                        mode_next    = rebm_pkg::KEY_IDLE;
                        release_next = '0;
                    end
                    else
                    begin
                        mode_next = rebm_pkg::KEY_HELD;
                    end
                end
            end
            rebm_pkg::KEY_HELD:
            begin
                if (press_inc > long_press_ticks)
                begin
                    press_next = '0;
                    mode_next  = rebm_pkg::KEY_DECIDE;
                end
                else
                begin
                    press_next   = press_inc;
                    release_next = press_inc;
                    if (btn)
                    begin
                        mode_next = rebm_pkg::KEY_RELEASED;
                        if (click_reg < 2'd2)
                        begin
                            click_next = click_reg + 2'd1;
                        end
                    end
                end
            end
            rebm_pkg::KEY_RELEASED:
            begin
                if (release_inc > second_press_window)
                begin
                    release_next = '0;
                    mode_next    = rebm_pkg::KEY_DECIDE;
                end
                else
                begin
                    release_next = release_inc;
                    if (gap_diff > $signed({2'b00, repress_gap_ticks}) && !btn
                        && click_reg < 2'd2)
                    begin
                        click_next = click_reg + 2'd1;
                    end
                end
            end
            rebm_pkg::KEY_DECIDE:
            begin
                click_next = '0;
                if (btn)
                begin
                    mode_next         = rebm_pkg::KEY_IDLE;
                    press_next        = '0;
                    release_next      = '0;
                    press.short_press = (click_reg <= 2'd1);
                end
                else
                begin
                    mode_next        = rebm_pkg::KEY_WAIT_UP;
                    press.long_press = 1'b1;
                end
            end
            rebm_pkg::KEY_WAIT_UP:
            begin
                if (btn)
                begin
                    mode_next    = rebm_pkg::KEY_IDLE;
                    press_next   = '0;
                    release_next = '0;
                end
            end
            default:
            begin
                if (!btn)
                begin
                    mode_next = rebm_pkg::KEY_DEBOUNCE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= rebm_pkg::KEY_IDLE;
            press_reg   <= '0;
            release_reg <= '0;
            click_reg   <= '0;
        end
        else if (en)
        begin
            mode_reg    <= mode_next;
            press_reg   <= press_next;
            release_reg <= release_next;
            click_reg   <= click_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) click_reg <= 2'd2)
        else $error("click count above saturation");

endmodule

// ===== hw/rtl/rotary_encoder_button_menu_top.sv =====
// rotary encoder and push button menu controller, top level
//
// one input item per sampling tick on the s_ stream: encoder pins, active-low
// button, hall flag and run busy flag. each accepted item yields exactly one
// result item on the m_ stream with the menu selection, cursor and edit state,
// the stored setting value, variant, enables, run flag, lamp drives and the
// one-tick clear_run pulse.
// the encoder step runs before the button step on the same pin sample.
// the result of an item is in the output register in the cycle after it is
// accepted. throughput is one item per cycle while m_tready is high, set by
// the single pass of next-state logic between the state and output registers.
// s_tready is high whenever the output register is empty or is being taken,
// so a stalled receiver holds the result and stops new items; no item is lost.
// the cfg channel writes the four timing registers, always ready; indexes
// beyond the list are ignored. write it only while the block is idle.
// reset clears the menu state to the power-up menu (no cursor, run off, lamp off)
// and loads the default timing values.
module rotary_encoder_button_menu_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // enc_a, enc_b, button_n, hall_present, run_busy, zero fill
    input  logic [rebm_pkg::IN_W-1:0]         s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // selection, cursor_on, edit_field, set_value, variant, hall_enable,
    // motor_enable, running, run_led_n, white_led, clear_run
    output logic [rebm_pkg::OUT_W-1:0]        m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rebm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rebm_pkg::CNT_W-1:0]        cfg_data
);

    logic [rebm_pkg::CNT_W-1:0] debounce_reg, long_reg, window_reg, gap_reg;

    logic       cursor_reg, cursor_next;
    logic [3:0] menu_reg, menu_next;
    logic [2:0] field_reg, field_next;
    logic [2:0] d4_reg, d4_next;
    logic [3:0] d3_reg, d3_next;
    logic [3:0] d2_reg, d2_next;
    logic [6:0] low_reg, low_next;
    logic [1:0] variant_reg, variant_next;
    logic       hall_en_reg, hall_en_next;
    logic       motor_en_reg, motor_en_next;
    logic       run_reg, run_next;
    logic       lamp_n_reg, lamp_n_next;
    logic       white_reg, white_next;
    logic       armed_reg, armed_next;
    logic       dir_right_reg, dir_right_next;
    logic       dir_left_reg, dir_left_next;
    logic       clear_next;

    logic                       out_valid_reg;
    logic [rebm_pkg::OUT_W-1:0] out_data_reg;

    logic       accept;
    logic       enc_a, enc_b, button_n, hall_present, run_busy;
    rebm_pkg::press_t press;

    logic [3:0]  enc_menu;
    logic [2:0]  c_d4;
    logic [3:0]  c_d3, c_d2;
    logic [6:0]  c_low;
    logic [16:0] value_sum;
    logic        value_sat;
    logic [15:0] value_out;

    function automatic logic [3:0] wrap_step(input logic [3:0] pos, input logic [3:0] top,
                                              input logic left, input logic right);
        logic [3:0] p;
        p = pos;
        if (!left)
        begin
            p = (p == 4'd0) ? top : p - 4'd1;
        end
        if (!right)
        begin
            p = (p >= top) ? 4'd0 : p + 4'd1;
        end
        return p;
    endfunction

    assign enc_a        = s_tdata[0];
    assign enc_b        = s_tdata[1];
    assign button_n     = s_tdata[2];
    assign hall_present = s_tdata[3];
    assign run_busy     = s_tdata[4];

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= rebm_pkg::DEBOUNCE_RST;
            long_reg     <= rebm_pkg::LONG_PRESS_RST;
            window_reg   <= rebm_pkg::SECOND_WIN_RST;
            gap_reg      <= rebm_pkg::REPRESS_GAP_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rebm_pkg::REG_DEBOUNCE:    debounce_reg <= cfg_data;
                rebm_pkg::REG_LONG_PRESS:  long_reg     <= cfg_data;
                rebm_pkg::REG_SECOND_WIN:  window_reg   <= cfg_data;
                rebm_pkg::REG_REPRESS_GAP: gap_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    rebm_button u_button (
        .clk                 (clk),
        .rst_n               (rst_n),
        .en                  (accept),
        .btn                 (button_n),
        .debounce_ticks      (debounce_reg),
        .long_press_ticks    (long_reg),
        .second_press_window (window_reg),
        .repress_gap_ticks   (gap_reg),
        .press               (press)
    );

    // encoder step
    always_comb
    begin
        armed_next     = armed_reg;
        dir_right_next = dir_right_reg;
        dir_left_next  = dir_left_reg;
        enc_menu       = menu_reg;
        c_d4           = d4_reg;
        c_d3           = d3_reg;
        c_d2           = d2_reg;
        c_low          = low_reg;
        if (cursor_reg)
        begin
            if (enc_a && enc_b)
            begin
                armed_next = 1'b1;
            end
            if (enc_a != enc_b)
            begin
                dir_right_next = enc_a;
                dir_left_next  = enc_b;
            end
            if (armed_reg && !enc_a && !enc_b)
            begin
                armed_next = 1'b0;
                case (field_reg)
                    rebm_pkg::FIELD_D4:
                    begin
                        enc_menu = wrap_step(menu_reg, rebm_pkg::TOP_MENU,
                                             dir_left_reg, dir_right_reg);
                        c_d4     = enc_menu[2:0];
                    end
                    rebm_pkg::FIELD_D3:
                    begin
                        enc_menu = wrap_step(menu_reg, rebm_pkg::TOP_DIGIT,
                                             dir_left_reg, dir_right_reg);
                        c_d3     = enc_menu;
                    end
                    rebm_pkg::FIELD_D2:
                    begin
                        enc_menu = wrap_step(menu_reg, rebm_pkg::TOP_DIGIT,
                                             dir_left_reg, dir_right_reg);
                        c_d2     = enc_menu;
                        c_low    = '0;
                    end
                    rebm_pkg::FIELD_NONE:
                    begin
                        enc_menu = wrap_step(menu_reg, rebm_pkg::TOP_MENU,
                                             dir_left_reg, dir_right_reg);
                    end
                    default: ;
                endcase
            end
        end
    end

    assign value_sum = 17'(c_d4) * 17'd10000 + 17'(c_d3) * 17'd1000
                     + 17'(c_d2) * 17'd100 + 17'(c_low);
    assign value_sat = value_sum[16];
    assign value_out = value_sat ? 16'hFFFF : value_sum[15:0];

    // button actions
    always_comb
    begin
        cursor_next   = cursor_reg;
        menu_next     = enc_menu;
        field_next    = field_reg;
        d4_next       = value_sat ? 3'd6 : c_d4;
        d3_next       = value_sat ? 4'd5 : c_d3;
        d2_next       = value_sat ? 4'd5 : c_d2;
        low_next      = value_sat ? 7'd35 : c_low;
        variant_next  = variant_reg;
        hall_en_next  = hall_en_reg;
        motor_en_next = motor_en_reg;
        run_next      = run_reg;
        lamp_n_next   = lamp_n_reg;
        white_next    = white_reg;
        clear_next    = 1'b0;
        if (press.long_press && !run_reg)
        begin
            cursor_next = !cursor_reg;
            if (!cursor_reg)
            begin
                menu_next = rebm_pkg::MENU_VAR;
            end
            else
            begin
                menu_next  = rebm_pkg::NO_CURSOR;
                field_next = rebm_pkg::FIELD_NONE;
            end
        end
        if (press.short_press)
        begin
            if (!cursor_reg)
            begin
                if (hall_present || variant_reg == rebm_pkg::VARIANT_LAST)
                begin
                    run_next    = !run_reg;
                    white_next  = 1'b1;
                    clear_next  = run_busy;
                    lamp_n_next = run_reg;
                end
            end
            else if (!run_reg)
            begin
                if (field_reg != rebm_pkg::FIELD_NONE)
                begin
                    menu_next  = {1'b0, field_reg};
                    field_next = rebm_pkg::FIELD_NONE;
                end
                else
                begin
                    case (enc_menu)
                        rebm_pkg::MENU_VAR:
                            variant_next = (variant_reg >= rebm_pkg::VARIANT_LAST)
                                         ? 2'd0 : variant_reg + 2'd1;
                        rebm_pkg::MENU_HALL:  hall_en_next  = !hall_en_reg;
                        rebm_pkg::MENU_MOTOR: motor_en_next = !motor_en_reg;
                        rebm_pkg::MENU_D4:
                        begin
                            field_next = rebm_pkg::FIELD_D4;
                            menu_next  = {1'b0, d4_next};
                        end
                        rebm_pkg::MENU_D3:
                        begin
                            field_next = rebm_pkg::FIELD_D3;
                            menu_next  = d3_next;
                        end
                        rebm_pkg::MENU_D2:
                        begin
                            field_next = rebm_pkg::FIELD_D2;
                            menu_next  = d2_next;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= 1'b0;
            menu_reg      <= rebm_pkg::NO_CURSOR;
            field_reg     <= rebm_pkg::FIELD_NONE;
            d4_reg        <= '0;
            d3_reg        <= '0;
            d2_reg        <= '0;
            low_reg       <= '0;
            variant_reg   <= '0;
            hall_en_reg   <= 1'b0;
            motor_en_reg  <= 1'b0;
            run_reg       <= 1'b0;
            lamp_n_reg    <= 1'b1;
            white_reg     <= 1'b0;
            armed_reg     <= 1'b0;
            dir_right_reg <= 1'b0;
            dir_left_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cursor_reg    <= cursor_next;
                menu_reg      <= menu_next;
                field_reg     <= field_next;
                d4_reg        <= d4_next;
                d3_reg        <= d3_next;
                d2_reg        <= d2_next;
                low_reg       <= low_next;
                variant_reg   <= variant_next;
                hall_en_reg   <= hall_en_next;
                motor_en_reg  <= motor_en_next;
                run_reg       <= run_next;
                lamp_n_reg    <= lamp_n_next;
                white_reg     <= white_next;
                armed_reg     <= armed_next;
                dir_right_reg <= dir_right_next;
                dir_left_reg  <= dir_left_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {clear_next, white_next, lamp_n_next, run_next, motor_en_next,
                             hall_en_next, variant_next, value_out, field_next, cursor_next,
                             menu_next};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !cursor_reg |-> (menu_reg == rebm_pkg::NO_CURSOR && field_reg == rebm_pkg::FIELD_NONE))
        else $error("menu position or edit field set outside cursor mode");

    assert property (@(posedge clk) disable iff (!rst_n)
        d4_reg <= 3'd6 && d3_reg <= 4'd9 && d2_reg <= 4'd9 && low_reg <= 7'd99
        && (d4_reg != 3'd6 || d3_reg <= 4'd5))
        else $error("stored value digits out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(press.short_press && press.long_press))
        else $error("short and long press in the same tick");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && press.long_press && !run_reg |=> cursor_reg != $past(cursor_reg))
        else $error("long press did not toggle cursor mode");

endmodule
